// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold at every rising edge of clk.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- rtl/fqr_pkg.sv -----
// Package for the linked thread queue: sizes, op and status codes, structs.
// No dependencies.
package fqr_pkg;

	localparam int MAX_IDS = 16;
	localparam int ID_W    = $clog2(MAX_IDS);
	localparam int CNT_W   = $clog2(MAX_IDS + 1);

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	typedef struct packed {
		logic            next_we;
		logic [ID_W-1:0] next_addr;
		logic [ID_W-1:0] next_data;
		logic            prev_we;
		logic [ID_W-1:0] prev_addr;
		logic [ID_W-1:0] prev_data;
	} link_wr_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  taken_id;
		logic [ID_W-1:0]  head_id;
		logic             is_empty;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

endpackage

// ----- rtl/fqr_req_if.sv -----
// Request channel: valid/ready handshake with op and thread_id.
// Depends on fqr_pkg.
interface fqr_req_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              op;
	logic [fqr_pkg::ID_W-1:0] thread_id;

	modport source (output valid, output op, output thread_id, input ready);
	modport sink   (input valid, input op, input thread_id, output ready);
endinterface

// ----- rtl/fqr_rsp_if.sv -----
// Result channel: valid/ready handshake with status, ids, empty flag, count.
// Depends on fqr_pkg.
interface fqr_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [fqr_pkg::ID_W-1:0]  taken_id;
	logic [fqr_pkg::ID_W-1:0]  head_id;
	logic                      is_empty;
	logic [fqr_pkg::CNT_W-1:0] entry_count;

	modport source (output valid, output status, output taken_id, output head_id,
		output is_empty, output entry_count, input ready);
	modport sink   (input valid, input status, input taken_id, input head_id,
		input is_empty, input entry_count, output ready);
endinterface

// ----- rtl/fqr_links.sv -----
// Next and previous link memories, one write and one registered read each.
// Read forwards a write to the same entry at the same edge. Depends on fqr_pkg.
module fqr_links (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [fqr_pkg::ID_W-1:0] rd_next_addr,
	input  logic [fqr_pkg::ID_W-1:0] rd_prev_addr,
	input  fqr_pkg::link_wr_t        wr,
	output logic [fqr_pkg::ID_W-1:0] next_s1,
	output logic [fqr_pkg::ID_W-1:0] prev_s1
);
	import fqr_pkg::*;

	logic [ID_W-1:0] next_mem [MAX_IDS];
	logic [ID_W-1:0] prev_mem [MAX_IDS];

	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
		if (rd_en) begin
			if (wr.next_we && (wr.next_addr == rd_next_addr)) begin
				next_s1 <= wr.next_data;
			end else begin
				next_s1 <= next_mem[rd_next_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.prev_we) begin
			prev_mem[wr.prev_addr] <= wr.prev_data;
		end
		if (rd_en) begin
			if (wr.prev_we && (wr.prev_addr == rd_prev_addr)) begin
				prev_s1 <= wr.prev_data;
			end else begin
				prev_s1 <= prev_mem[rd_prev_addr];
			end
		end
	end

endmodule

// ----- rtl/fqr_core.sv -----
// Queue state (head, tail, count, queued marks) and the per-request update.
// Issues link writes and builds the result. Depends on fqr_pkg.
module fqr_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic [1:0]               op_s1,
	input  logic [fqr_pkg::ID_W-1:0] id_s1,
	input  logic [fqr_pkg::ID_W-1:0] link_next,
	input  logic [fqr_pkg::ID_W-1:0] link_prev,
	output fqr_pkg::rsp_t            res,
	output fqr_pkg::link_wr_t        wr,
	output logic [fqr_pkg::ID_W-1:0] head_nxt
);
	import fqr_pkg::*;

	logic [ID_W-1:0]    head_q, tail_q, head_d, tail_d, tid;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [MAX_IDS-1:0] mark_q, mark_d;
	logic               nonempty, at_head, at_tail, do_unlink;
	op_t                op;
	status_t            status;
	logic [ID_W-1:0]    taken;
	link_wr_t           wr_c;

	assign op       = op_t'(op_s1);
	assign tid      = (op == OP_DEQ) ? head_q : id_s1;
	assign nonempty = (count_q != '0);
	assign at_head  = (tid == head_q);
	assign at_tail  = (tid == tail_q);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		mark_d    = mark_q;
		status    = ST_DONE;
		taken     = '0;
		wr_c      = '0;
		do_unlink = 1'b0;
		case (op)
			OP_ENQ: begin
				if (mark_q[id_s1]) begin
					status = ST_DUP;
				end else begin
					if (!nonempty) begin
						head_d = id_s1;
					end else begin
						wr_c.next_we   = 1'b1;
						wr_c.next_addr = tail_q;
						wr_c.next_data = id_s1;
						wr_c.prev_we   = 1'b1;
						wr_c.prev_addr = id_s1;
						wr_c.prev_data = tail_q;
					end
					tail_d        = id_s1;
					mark_d[id_s1] = 1'b1;
					count_d       = count_q + CNT_W'(1);
				end
			end
			OP_DEQ: begin
				if (!nonempty) begin
					status = ST_EMPTY;
				end else begin
					taken     = head_q;
					do_unlink = 1'b1;
				end
			end
			OP_REM: begin
				if (!nonempty) begin
					status = ST_EMPTY;
				end else if (!mark_q[id_s1]) begin
					status = ST_ABSENT;
				end else begin
					taken     = id_s1;
					do_unlink = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (do_unlink) begin
			if (at_head && at_tail) begin
				head_d = '0;
				tail_d = '0;
			end else if (at_head) begin
				head_d = link_next;
			end else if (at_tail) begin
				tail_d = link_prev;
			end else begin
				wr_c.next_we   = 1'b1;
				wr_c.next_addr = link_prev;
				wr_c.next_data = link_next;
				wr_c.prev_we   = 1'b1;
				wr_c.prev_addr = link_next;
				wr_c.prev_data = link_prev;
			end
			mark_d[tid] = 1'b0;
			count_d     = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		wr         = wr_c;
		wr.next_we = wr_c.next_we & fire;
		wr.prev_we = wr_c.prev_we & fire;
	end

	assign res.status      = status;
	assign res.taken_id    = taken;
	assign res.head_id     = (count_d != '0) ? head_d : '0;
	assign res.is_empty    = (count_d == '0);
	assign res.entry_count = count_d;

	assign head_nxt = fire ? head_d : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			mark_q  <= '0;
		end else if (fire) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			mark_q  <= mark_d;
		end
	end

endmodule

// ----- rtl/fifo_queue_with_removal.sv -----
// Linked FIFO of thread ids with enqueue, dequeue and remove-by-id.
// Stages: request stage (request and link reads), then output register (result).
// Throughput: one request per cycle while rsp.ready is high; update is combinational.
// Reset clears head, tail, count and queued marks; the link memories are
// not cleared and need no clearing pass, so requests are taken right away.
`include "assert_macros.svh"

module fifo_queue_with_removal (
	input  logic       clk,
	input  logic       arst_n,
	fqr_req_if.sink    req,
	fqr_rsp_if.source  rsp
);
	import fqr_pkg::*;

	logic            valid_s1, fire, accept, out_valid_q;
	logic [1:0]      op_s1;
	logic [ID_W-1:0] id_s1, link_next_s1, link_prev_s1, head_nxt, rd_next_addr;
	rsp_t            res, out_q;
	link_wr_t        wr;

	assign fire      = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;
	assign accept    = req.valid && req.ready;

	// dequeue reads the link of the head as it stands after the request in flight
	assign rd_next_addr = (op_t'(req.op) == OP_DEQ) ? head_nxt : req.thread_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.op;
			id_s1 <= req.thread_id;
		end
	end

	fqr_links u_links (
		.clk          (clk),
		.rd_en        (accept),
		.rd_next_addr (rd_next_addr),
		.rd_prev_addr (req.thread_id),
		.wr           (wr),
		.next_s1      (link_next_s1),
		.prev_s1      (link_prev_s1)
	);

	fqr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op_s1     (op_s1),
		.id_s1     (id_s1),
		.link_next (link_next_s1),
		.link_prev (link_prev_s1),
		.res       (res),
		.wr        (wr),
		.head_nxt  (head_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.taken_id    = out_q.taken_id;
	assign rsp.head_id     = out_q.head_id;
	assign rsp.is_empty    = out_q.is_empty;
	assign rsp.entry_count = out_q.entry_count;

	`ASSERT_IMPLY(a_empty_cnt, rsp.valid, rsp.is_empty == (rsp.entry_count == '0), "empty flag vs count")
	`ASSERT_IMPLY(a_empty_head, rsp.valid && rsp.is_empty, rsp.head_id == '0, "head not zero when empty")
	`ASSERT_IMPLY(a_fail_taken, rsp.valid && (rsp.status != ST_DONE), rsp.taken_id == '0, "id taken on failed request")
	`ASSERT_ALWAYS(a_ready_idle, valid_s1 || req.ready, "request stalled with empty stage")

endmodule

// ----- tb/testbench.sv -----
// Testbench for fifo_queue_with_removal: directed and random requests with
// random idling on both channels, checked against a queue tracker class.
// Depends on fqr_pkg, fqr_req_if, fqr_rsp_if and the block itself.
`timescale 1ns / 1ps

module testbench;
	import fqr_pkg::*;

	class ready_queue_tracker;
		logic [ID_W-1:0] next_of [MAX_IDS];
		logic [ID_W-1:0] prev_of [MAX_IDS];
		bit marked [MAX_IDS];
		logic [ID_W-1:0] head;
		logic [ID_W-1:0] tail;
		int total;
		rsp_t outcome_fifo [$];
		int errors;

		function new();
			foreach (marked[i]) begin
				next_of[i] = '0;
				prev_of[i] = '0;
				marked[i] = 1'b0;
			end
			head = '0;
			tail = '0;
			total = 0;
			errors = 0;
		endfunction

		function int pending();
			return outcome_fifo.size();
		endfunction

		function bit is_queued(int id);
			return marked[id];
		endfunction

		function void unlink_entry(logic [ID_W-1:0] id);
			logic [ID_W-1:0] p;
			logic [ID_W-1:0] n;
			p = prev_of[id];
			n = next_of[id];
			if (id == head && id == tail) begin
				head = '0;
				tail = '0;
			end else if (id == head) begin
				head = n;
			end else if (id == tail) begin
				tail = p;
			end else begin
				next_of[p] = n;
				prev_of[n] = p;
			end
			marked[id] = 1'b0;
			total--;
		endfunction

		// predict the response of one accepted request and queue it
		function void apply_request(op_t op, logic [ID_W-1:0] id);
			rsp_t r;
			r = '0;
			r.status = ST_DONE;
			case (op)
				OP_ENQ: begin
					if (marked[id]) begin
						r.status = ST_DUP;
					end else begin
						if (total == 0) begin
							head = id;
						end else begin
							next_of[tail] = id;
							prev_of[id] = tail;
						end
						tail = id;
						marked[id] = 1'b1;
						total++;
					end
				end
				OP_DEQ: begin
					if (total == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.taken_id = head;
						unlink_entry(head);
					end
				end
				OP_REM: begin
					if (total == 0) begin
						r.status = ST_EMPTY;
					end else if (!marked[id]) begin
						r.status = ST_ABSENT;
					end else begin
						r.taken_id = id;
						unlink_entry(id);
					end
				end
				default: begin
				end
			endcase
			r.head_id = (total != 0) ? head : '0;
			r.is_empty = (total == 0);
			r.entry_count = total[CNT_W-1:0];
			outcome_fifo.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_outcome(rsp_t got);
			rsp_t want;
			if (outcome_fifo.size() == 0) begin
				report($sformatf("response with no request pending, status %0d",
					got.status));
				return;
			end
			want = outcome_fifo.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.taken_id !== want.taken_id)
				report($sformatf("taken_id got %0d want %0d", got.taken_id,
					want.taken_id));
			if (got.head_id !== want.head_id)
				report($sformatf("head_id got %0d want %0d", got.head_id, want.head_id));
			if (got.is_empty !== want.is_empty)
				report($sformatf("is_empty got %0d want %0d", got.is_empty,
					want.is_empty));
			if (got.entry_count !== want.entry_count)
				report($sformatf("entry_count got %0d want %0d", got.entry_count,
					want.entry_count));
		endtask
	endclass

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 780;
	localparam int PHASE_LEN = 40;

	logic clk = 1'b0;
	logic arst_n;
	bit no_idle = 1'b0;
	int idle_cycles = 0;
	ready_queue_tracker sb = new();

	fqr_req_if req_ch ();
	fqr_rsp_if rsp_ch ();

	fifo_queue_with_removal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	// first id from a random start whose queued mark equals want
	function automatic logic [ID_W-1:0] pick_id(bit want);
		int start;
		int id;
		start = $urandom_range(0, MAX_IDS - 1);
		for (int k = 0; k < MAX_IDS; k++) begin
			id = (start + k) % MAX_IDS;
			if (sb.is_queued(id) == want)
				return id[ID_W-1:0];
		end
		return start[ID_W-1:0];
	endfunction

	task automatic send_request(op_t op, logic [ID_W-1:0] id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.thread_id <= id;
		do @(posedge clk); while (!req_ch.ready);
		sb.apply_request(op, id);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		rsp_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.status = status_t'(rsp_ch.status);
			got.taken_id = rsp_ch.taken_id;
			got.head_id = rsp_ch.head_id;
			got.is_empty = rsp_ch.is_empty;
			got.entry_count = rsp_ch.entry_count;
			sb.check_outcome(got);
		end
	end

	initial begin
		int mode;
		int roll;
		op_t op;
		logic [ID_W-1:0] id;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_ENQ;
		req_ch.thread_id <= '0;
		rsp_ch.ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_DEQ, 4'd0);
		send_request(OP_REM, 4'd5);
		send_request(OP_NOP, 4'd15);
		send_request(OP_ENQ, 4'd0);
		send_request(OP_ENQ, 4'd15);
		send_request(OP_ENQ, 4'd0);
		send_request(OP_REM, 4'd7);
		send_request(OP_ENQ, 4'd7);
		send_request(OP_ENQ, 4'd3);
		send_request(OP_ENQ, 4'd10);
		send_request(OP_REM, 4'd7);
		send_request(OP_REM, 4'd10);
		send_request(OP_DEQ, 4'd9);
		send_request(OP_REM, 4'd15);
		send_request(OP_REM, 4'd3);
		send_request(OP_DEQ, 4'd0);
		send_request(OP_ENQ, 4'd5);
		send_request(OP_ENQ, 4'd5);
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_LEN == 0) begin
				mode = $urandom_range(0, 2);
				no_idle = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0)
					hold_until_drained();
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				op = op_t'($urandom_range(0, 3));
				id = ID_W'($urandom_range(0, MAX_IDS - 1));
			end else if ((mode == 0 && roll < 75) || (mode == 1 && roll < 30)
					|| (mode == 2 && roll < 54)) begin
				op = OP_ENQ;
				id = pick_id(1'b0);
			end else if ($urandom_range(0, 1) == 0) begin
				op = OP_DEQ;
				id = ID_W'($urandom_range(0, MAX_IDS - 1));
			end else begin
				op = OP_REM;
				id = pick_id(1'b1);
			end
			send_request(op, id);
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d responses never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fqr_pkg.sv
rtl/fqr_req_if.sv
rtl/fqr_rsp_if.sv
rtl/fqr_links.sv
rtl/fqr_core.sv
rtl/fifo_queue_with_removal.sv
tb/testbench.sv
